/* design/prd_pkg.sv */
// Package for the packet reassembly deframer: shared types, codes and
// fixed header layout constants. No dependencies.
package prd_pkg;

    localparam int HEADER_BYTES     = 8;
    localparam int MIN_PACKET_BYTES = 10;

    localparam int POS_W       = 4;
    localparam int INDEX_W     = 12;
    localparam int COUNT_W     = 24;
    localparam int DROP_W      = 32;

    localparam logic [POS_W-1:0] POS_MAX   = '1;
    localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W:0]   MIN_LEN   = (POS_W + 1)'(MIN_PACKET_BYTES);

    // header byte positions
    localparam logic [POS_W-1:0] HDR_POS_VERSION = 4'd0;
    localparam logic [POS_W-1:0] HDR_POS_INDEX   = 4'd1;
    localparam logic [POS_W-1:0] HDR_POS_COUNT0  = 4'd2;
    localparam logic [POS_W-1:0] HDR_POS_COUNT1  = 4'd3;
    localparam logic [POS_W-1:0] HDR_POS_COUNT2  = 4'd4;
    localparam logic [POS_W-1:0] HDR_POS_DEST    = 4'd5;
    localparam logic [POS_W-1:0] HDR_POS_FUSER   = 4'd7;

    // decoupling queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_MALFORMED = 2'd0,
        VERDICT_SEQUENCE  = 2'd1,
        VERDICT_CONTINUE  = 2'd2,
        VERDICT_DONE      = 2'd3
    } verdict_t;

    // one request from the front to the back
    typedef struct packed {
        logic               is_tail;
        logic [7:0]         data;
        logic               err;
        logic               short_pkt;
        logic               version_bad;
        logic [INDEX_W-1:0] hdr_index;
        logic [COUNT_W-1:0] hdr_count;
        logic [7:0]         hdr_dest;
        logic [7:0]         hdr_first_user;
    } entry_t;

    // one result item
    typedef struct packed {
        logic              result_kind;
        logic [7:0]        payload_byte;
        verdict_t          verdict;
        logic [7:0]        frame_dest;
        logic [7:0]        first_user;
        logic [6:0]        last_user;
        logic              ssi_error;
        logic              abandoned_previous;
        logic [DROP_W-1:0] drop_total;
    } result_t;

endpackage

/* design/prd_front.sv */
// Front end of the deframer: counts byte position, captures header fields
// and classifies each byte into a queue request. Uses prd_pkg.
module prd_front
    import prd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       packet_last,
    input  logic       packet_error,
    output logic       enq_valid,
    output entry_t     enq_entry
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         dest_reg, dest_next;
    logic [7:0]         fuser_reg, fuser_next;
    logic               vbad_reg, vbad_next;

    always_comb
    begin
        pos_next   = pos_reg;
        index_next = index_reg;
        count_next = count_reg;
        dest_next  = dest_reg;
        fuser_next = fuser_reg;
        vbad_next  = vbad_reg;
        if (accept)
        begin
            if (packet_last)
            begin
                pos_next = '0;
            end
            else
            begin
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                case (pos_reg)
                    HDR_POS_VERSION:
                    begin
                        vbad_next  = (data_byte[3:0] != 4'd0);
                        index_next = {index_reg[INDEX_W-1:4], data_byte[7:4]};
                    end
                    HDR_POS_INDEX:  index_next = {data_byte, index_reg[3:0]};
                    HDR_POS_COUNT0: count_next = {count_reg[23:8], data_byte};
                    HDR_POS_COUNT1: count_next = {count_reg[23:16], data_byte, count_reg[7:0]};
                    HDR_POS_COUNT2: count_next = {data_byte, count_reg[15:0]};
                    HDR_POS_DEST:   dest_next  = data_byte;
                    HDR_POS_FUSER:  fuser_next = data_byte;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            index_reg <= '0;
            count_reg <= '0;
            dest_reg  <= '0;
            fuser_reg <= '0;
            vbad_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            index_reg <= index_next;
            count_reg <= count_next;
            dest_reg  <= dest_next;
            fuser_reg <= fuser_next;
            vbad_reg  <= vbad_next;
        end
    end

    // Forward tails always; forward body bytes only past the header of a
    // packet with a good version. Header bytes end here.
    always_comb
    begin
        enq_valid = accept && (packet_last || ((pos_reg > HDR_LAST) && !vbad_reg));
        enq_entry.is_tail        = packet_last;
        enq_entry.data           = data_byte;
        enq_entry.err            = packet_error;
        enq_entry.short_pkt      = ({1'b0, pos_reg} + 1'b1) < MIN_LEN;
        enq_entry.version_bad    = vbad_reg;
        enq_entry.hdr_index      = index_reg;
        enq_entry.hdr_count      = count_reg;
        enq_entry.hdr_dest       = dest_reg;
        enq_entry.hdr_first_user = fuser_reg;
    end

endmodule

/* design/prd_queue.sv */
// Short request queue between front and back of the deframer.
// Uses prd_pkg for the entry type and depth.
module prd_queue
    import prd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_entry,
    input  logic   rd_en,
    output logic   rd_valid,
    output entry_t rd_entry,
    output logic   full
);

    entry_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("write request while queue full");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

/* design/prd_back.sv */
// Back end of the deframer: checks sequence against the frame in progress,
// commits state at tails and holds the result register. Uses prd_pkg.
module prd_back
    import prd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    ssi_enable,
    input  logic    req_valid,
    input  entry_t  req_entry,
    output logic    req_take,
    input  logic    pop,
    output logic    res_valid,
    output result_t res
);

    logic [INDEX_W-1:0] exp_index_reg, exp_index_next;
    logic [COUNT_W-1:0] seg_count_reg, seg_count_next;
    logic [7:0]         sdest_reg, sdest_next;
    logic [7:0]         sfuser_reg, sfuser_next;
    logic [DROP_W-1:0]  drop_reg, drop_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               seq_ok;
    logic               malformed;
    logic [COUNT_W-1:0] seg_base;
    logic               produce;

    assign req_take  = req_valid && (!out_valid_reg || pop);
    assign seq_ok    = (req_entry.hdr_count == '0)
                    || ((req_entry.hdr_index == exp_index_reg)
                        && (req_entry.hdr_count == seg_count_reg));
    assign malformed = req_entry.err || req_entry.short_pkt || req_entry.version_bad;

    always_comb
    begin
        exp_index_next = exp_index_reg;
        seg_count_next = seg_count_reg;
        sdest_next     = sdest_reg;
        sfuser_next    = sfuser_reg;
        drop_next      = drop_reg;
        seg_base       = seg_count_reg;
        produce        = 1'b0;
        out_next       = '0;

        if (req_take)
        begin
            if (!req_entry.is_tail)
            begin
                produce               = seq_ok;
                out_next.result_kind  = KIND_PAYLOAD;
                out_next.payload_byte = req_entry.data;
            end
            else
            begin
                produce              = 1'b1;
                out_next.result_kind = KIND_VERDICT;
                if (malformed)
                begin
                    drop_next           = drop_reg + 1'b1;
                    out_next.verdict    = VERDICT_MALFORMED;
                    out_next.drop_total = drop_next;
                end
                else if (!seq_ok)
                begin
                    drop_next           = drop_reg + 1'b1;
                    seg_count_next      = '0;
                    out_next.verdict    = VERDICT_SEQUENCE;
                    out_next.drop_total = drop_next;
                end
                else
                begin
                    // frame start: take the new header, abandon any partial frame
                    if (req_entry.hdr_count == '0)
                    begin
                        out_next.abandoned_previous = (seg_count_reg != '0);
                        exp_index_next = req_entry.hdr_index;
                        sdest_next     = req_entry.hdr_dest;
                        sfuser_next    = req_entry.hdr_first_user;
                        seg_base       = '0;
                    end
                    out_next.frame_dest = sdest_next;
                    out_next.first_user = sfuser_next;
                    out_next.drop_total = drop_reg;
                    if (req_entry.data[7])
                    begin
                        seg_count_next     = '0;
                        out_next.verdict   = VERDICT_DONE;
                        out_next.last_user = req_entry.data[6:0];
                        out_next.ssi_error = ssi_enable & req_entry.data[0];
                    end
                    else
                    begin
                        seg_count_next   = seg_base + 1'b1;
                        out_next.verdict = VERDICT_CONTINUE;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_index_reg <= '0;
            seg_count_reg <= '0;
            sdest_reg     <= '0;
            sfuser_reg    <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            exp_index_reg <= exp_index_next;
            seg_count_reg <= seg_count_next;
            sdest_reg     <= sdest_next;
            sfuser_reg    <= sfuser_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result changed before pop");

    a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && req_entry.is_tail && malformed) |=> (drop_reg == $past(drop_reg) + 1'b1))
        else $error("malformed tail did not count a drop");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && out_next.result_kind == KIND_VERDICT && out_next.verdict == VERDICT_DONE)
        |=> (seg_count_reg == '0))
        else $error("segment count not cleared at frame done");

endmodule

/* design/packet_reassembly_deframer_core.sv */
// Top level of the packet reassembly deframer: front end, request queue,
// back end and the SSI enable register. Uses prd_pkg, prd_front, prd_queue, prd_back.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-----------------------------------
//  input     | in        | push / full          | data_byte, packet_last, packet_error
//  result    | out       | pop / empty          | result_kind .. drop_total
//  config    | in        | cfg_valid / cfg_ready| cfg_data (ssi_enable)
//
//  One byte is accepted per cycle while the request queue is not full; a byte is
//  classified by the front, held in the queue, then checked by the back into the
//  result register. Throughput is set by the two-entry request queue and the single
//  result register: full rises only while the result side stalls.
//  rst_n clears all control and reassembly state and sets ssi_enable to 1.
//  cfg_ready is always high; write only while the block is idle.
module packet_reassembly_deframer_core
    import prd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              packet_last,
    input  logic              packet_error,

    output logic              empty,
    input  logic              pop,
    output logic              result_kind,
    output logic [7:0]        payload_byte,
    output logic [1:0]        verdict,
    output logic [7:0]        frame_dest,
    output logic [7:0]        first_user,
    output logic [6:0]        last_user,
    output logic              ssi_error,
    output logic              abandoned_previous,
    output logic [DROP_W-1:0] drop_total,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    logic    ssi_enable_reg, ssi_enable_next;
    logic    in_accept;
    logic    enq_valid;
    entry_t  enq_entry;
    logic    q_valid;
    entry_t  q_entry;
    logic    q_take;
    logic    res_valid;
    result_t res;

    // config: always ready, take the write on valid
    assign cfg_ready       = 1'b1;
    assign ssi_enable_next = (cfg_valid && cfg_ready) ? cfg_data : ssi_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssi_enable_reg <= 1'b1;
        end
        else
        begin
            ssi_enable_reg <= ssi_enable_next;
        end
    end

    // accept a byte whenever the request queue has room
    assign in_accept = push && !full;

    prd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .data_byte    (data_byte),
        .packet_last  (packet_last),
        .packet_error (packet_error),
        .enq_valid    (enq_valid),
        .enq_entry    (enq_entry)
    );

    // decouple classification from commit so each side stalls on its own
    prd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (enq_valid),
        .wr_entry (enq_entry),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_entry (q_entry),
        .full     (full)
    );

    // check sequence, commit at tails, hold the oldest result until popped
    prd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ssi_enable (ssi_enable_reg),
        .req_valid  (q_valid),
        .req_entry  (q_entry),
        .req_take   (q_take),
        .pop        (pop),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign empty              = !res_valid;
    assign result_kind        = res.result_kind;
    assign payload_byte       = res.payload_byte;
    assign verdict            = res.verdict;
    assign frame_dest         = res.frame_dest;
    assign first_user         = res.first_user;
    assign last_user          = res.last_user;
    assign ssi_error          = res.ssi_error;
    assign abandoned_previous = res.abandoned_previous;
    assign drop_total         = res.drop_total;

    a_cfg_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (ssi_enable_reg == $past(cfg_data)))
        else $error("config write not applied");

    a_no_enq_without_accept: assert property (@(posedge clk) disable iff (!rst_n)
        enq_valid |-> in_accept)
        else $error("request queued without an accepted byte");

    a_empty_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_PAYLOAD)
        |-> (drop_total == '0 && verdict == VERDICT_MALFORMED))
        else $error("payload result carries verdict fields");

endmodule
